>>> hw/rtl/c2p_pkg.sv
// Shared constants, types and the arctangent table for the cartesian-to-polar converter.
package c2p_pkg;

  // Coordinate and result width
  localparam int COORD_W = 8;

  // Integer square root of 4*(x*x+y*y): operand fits in 18 bits, nine digits
  localparam int SQ_W       = 18;
  localparam int SQRT_STEPS = 9;

  // Widest table resolution: atan(2^-i) in units of 2^-24 angle steps
  localparam int TAB_FRAC = 24;
  localparam int TAB_LEN  = 24;
  localparam int TAB_W    = 32;

  localparam logic [TAB_W-1:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Quadrant and special-case flags that ride along the pipeline
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic ax_zero;
    logic ay_zero;
  } c2p_flags_t;

  // Square root working state: remainder and partial root
  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } c2p_sqrt_t;

endpackage

>>> hw/rtl/c2p_point_if.sv
// Valid/ready channel carrying one cartesian point.
interface c2p_point_if
  import c2p_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

>>> hw/rtl/c2p_polar_if.sv
// Valid/ready channel carrying one polar result.
interface c2p_polar_if
  import c2p_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] radius_code;
  logic signed [COORD_W-1:0] angle_code;

  modport source (output valid, output radius_code, output angle_code, input ready);
  modport sink   (input valid, input radius_code, input angle_code, output ready);
endinterface

>>> hw/rtl/c2p_cell.sv
// One pipeline cell: a vectoring CORDIC rotation plus, in the leading cells, one square root digit.
module c2p_cell
  import c2p_pkg::*;
#(
  parameter int STAGE      = 0,
  parameter int GUARD_BITS = 16,
  parameter int VEC_W      = 27,
  parameter int ANG_W      = 25
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  c2p_flags_t              flags_i,
  input  c2p_sqrt_t               sqrt_i,
  input  logic signed [VEC_W-1:0] vx_i,
  input  logic signed [VEC_W-1:0] vy_i,
  input  logic signed [ANG_W-1:0] z_i,
  output logic                    valid_o,
  output c2p_flags_t              flags_o,
  output c2p_sqrt_t               sqrt_o,
  output logic signed [VEC_W-1:0] vx_o,
  output logic signed [VEC_W-1:0] vy_o,
  output logic signed [ANG_W-1:0] z_o
);

  // Table entry brought to 2^-GUARD_BITS steps, round half up
  localparam int SH      = TAB_FRAC - GUARD_BITS;
  localparam int RND_POS = (SH > 0) ? SH - 1 : 0;
  localparam logic [TAB_W:0] TAB_RAW = {1'b0, ATAN_TAB[STAGE]};
  localparam logic [TAB_W:0] TAB_RND =
      (SH > 0) ? ((TAB_RAW + ((TAB_W+1)'(1) << RND_POS)) >> SH) : TAB_RAW;
  localparam logic signed [ANG_W-1:0] STEP = ANG_W'(TAB_RND);

  logic                    valid_q;
  c2p_flags_t              flags_q;
  c2p_sqrt_t               sqrt_q, sqrt_d;
  logic signed [VEC_W-1:0] vx_q, vx_d, vy_q, vy_d;
  logic signed [ANG_W-1:0] z_q, z_d;
  logic signed [VEC_W-1:0] sh_x, sh_y;

  // Rotation toward the x axis
  assign sh_x = vx_i >>> STAGE;
  assign sh_y = vy_i >>> STAGE;

  always_comb begin
    if (!vy_i[VEC_W-1]) begin
      vx_d = vx_i + sh_y;
      vy_d = vy_i - sh_x;
      z_d  = z_i + STEP;
    end else begin
      vx_d = vx_i - sh_y;
      vy_d = vy_i + sh_x;
      z_d  = z_i - STEP;
    end
  end

  // Square root digit, only in the leading cells
  generate
    if (STAGE < SQRT_STEPS) begin : g_sqrt
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - STAGE));
      logic [SQ_W-1:0] trial;
      assign trial = sqrt_i.root + BIT;
      always_comb begin
        if (sqrt_i.rem >= trial) begin
          sqrt_d.rem  = sqrt_i.rem - trial;
          sqrt_d.root = (sqrt_i.root >> 1) + BIT;
        end else begin
          sqrt_d.rem  = sqrt_i.rem;
          sqrt_d.root = sqrt_i.root >> 1;
        end
      end
    end else begin : g_pass
      assign sqrt_d = sqrt_i;
    end
  endgenerate

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= flags_i;
      sqrt_q  <= sqrt_d;
      vx_q    <= vx_d;
      vy_q    <= vy_d;
      z_q     <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;
  assign sqrt_o  = sqrt_q;
  assign vx_o    = vx_q;
  assign vy_o    = vy_q;
  assign z_o     = z_q;

endmodule

>>> hw/rtl/cartesian_to_polar_8bit.sv
// Top level: pipelined cartesian-to-polar converter built from a row of CORDIC cells.
//
//   channel  | dir | payload                    | transfer
//   point_i  | in  | x_coord, y_coord (s8, s8)  | valid && ready
//   polar_o  | out | radius_code, angle_code    | valid && ready
//
// One point per cycle while the output is not stalled; each point passes through the input
// register, one cell per CORDIC iteration and the output register. The square root digits run
// in the first nine cells alongside the rotations.
// Reset clears only the valid bits of the pipeline.
// A stalled output freezes the whole row; point_i.ready = !polar_o.valid || polar_o.ready.
module cartesian_to_polar_8bit
  import c2p_pkg::*;
#(
  parameter int CORDIC_STAGES = 16,
  parameter int GUARD_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  c2p_point_if.sink   point_i,
  c2p_polar_if.source polar_o
);

  localparam int VEC_W = GUARD_BITS + 11;
  localparam int ANG_W = GUARD_BITS + 9;
  localparam logic signed [ANG_W-1:0] FULL = ANG_W'(64) <<< GUARD_BITS;
  localparam logic signed [ANG_W-1:0] HALF = ANG_W'(1) <<< (GUARD_BITS - 1);

  logic en;
  logic out_valid_q;

  // Pipeline advances whenever the output slot is free or being taken
  assign en            = !out_valid_q || polar_o.ready;
  assign point_i.ready = en;

  // Inter-cell links
  logic                    valid_s [CORDIC_STAGES+1];
  c2p_flags_t              flags_s [CORDIC_STAGES+1];
  c2p_sqrt_t               sqrt_s  [CORDIC_STAGES+1];
  logic signed [VEC_W-1:0] vx_s    [CORDIC_STAGES+1];
  logic signed [VEC_W-1:0] vy_s    [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0] z_s     [CORDIC_STAGES+1];

  // Input register: magnitudes, flags and sum of squares
  logic                    in_valid_q;
  c2p_flags_t              in_flags_q, in_flags_d;
  c2p_sqrt_t               in_sqrt_q, in_sqrt_d;
  logic signed [VEC_W-1:0] in_vx_q, in_vx_d, in_vy_q, in_vy_d;
  logic [COORD_W-1:0]      ax, ay;
  logic [2*COORD_W-1:0]    sq_x, sq_y;

  always_comb begin
    ax                 = point_i.x_coord[COORD_W-1] ? COORD_W'(-point_i.x_coord)
                                                    : COORD_W'(point_i.x_coord);
    ay                 = point_i.y_coord[COORD_W-1] ? COORD_W'(-point_i.y_coord)
                                                    : COORD_W'(point_i.y_coord);
    sq_x               = ax * ax;
    sq_y               = ay * ay;
    in_flags_d.x_neg   = point_i.x_coord[COORD_W-1];
    in_flags_d.y_neg   = point_i.y_coord[COORD_W-1];
    in_flags_d.ax_zero = (ax == '0);
    in_flags_d.ay_zero = (ay == '0);
    in_sqrt_d.rem      = {(SQ_W-2)'(sq_x) + (SQ_W-2)'(sq_y), 2'b00};
    in_sqrt_d.root     = '0;
    in_vx_d            = VEC_W'(ax) <<< GUARD_BITS;
    in_vy_d            = VEC_W'(ay) <<< GUARD_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= point_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_flags_q <= in_flags_d;
      in_sqrt_q  <= in_sqrt_d;
      in_vx_q    <= in_vx_d;
      in_vy_q    <= in_vy_d;
    end
  end

  assign valid_s[0] = in_valid_q;
  assign flags_s[0] = in_flags_q;
  assign sqrt_s[0]  = in_sqrt_q;
  assign vx_s[0]    = in_vx_q;
  assign vy_s[0]    = in_vy_q;
  assign z_s[0]     = '0;

  // Row of CORDIC cells
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    c2p_cell #(
      .STAGE      (k),
      .GUARD_BITS (GUARD_BITS),
      .VEC_W      (VEC_W),
      .ANG_W      (ANG_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[k]),
      .flags_i (flags_s[k]),
      .sqrt_i  (sqrt_s[k]),
      .vx_i    (vx_s[k]),
      .vy_i    (vy_s[k]),
      .z_i     (z_s[k]),
      .valid_o (valid_s[k+1]),
      .flags_o (flags_s[k+1]),
      .sqrt_o  (sqrt_s[k+1]),
      .vx_o    (vx_s[k+1]),
      .vy_o    (vy_s[k+1]),
      .z_o     (z_s[k+1])
    );
  end

  // Angle code: clamp, special cases, rounding, quadrant adjust
  c2p_flags_t              fl;
  logic signed [ANG_W-1:0] z_end, zc, z_up, z_dn;
  logic [COORD_W-1:0]      ang_base, ang_d;

  assign fl    = flags_s[CORDIC_STAGES];
  assign z_end = z_s[CORDIC_STAGES];

  always_comb begin
    if (fl.ay_zero) begin
      zc = '0;
    end else if (fl.ax_zero) begin
      zc = FULL;
    end else if (z_end < 0) begin
      zc = '0;
    end else if (z_end > FULL) begin
      zc = FULL;
    end else begin
      zc = z_end;
    end
    z_up = (zc + HALF) >>> GUARD_BITS;
    z_dn = (zc - HALF) >>> GUARD_BITS;
    if (fl.x_neg != fl.y_neg) begin
      ang_base = COORD_W'(-z_up);
    end else if (zc < HALF) begin
      ang_base = '0;
    end else begin
      ang_base = COORD_W'(z_dn);
    end
    if (fl.x_neg && fl.y_neg) begin
      ang_d = ang_base - COORD_W'(127);
    end else if (fl.x_neg) begin
      ang_d = ang_base + COORD_W'(128);
    end else if (!fl.y_neg && !fl.ay_zero) begin
      ang_d = ang_base + COORD_W'(1);
    end else begin
      ang_d = ang_base;
    end
  end

  // Radius code from root t of 4*(x*x+y*y): t/2 - 127.5 truncated toward zero
  localparam int ROOT_W = 9;
  logic [ROOT_W-1:0]  root_t;
  logic               exact;
  logic [COORD_W-1:0] m, rad_d;

  assign root_t = sqrt_s[CORDIC_STAGES].root[ROOT_W-1:0];
  assign exact  = (sqrt_s[CORDIC_STAGES].rem == '0);

  always_comb begin
    m = COORD_W'(ROOT_W'(255) - root_t);
    if (root_t >= ROOT_W'(255)) begin
      rad_d = COORD_W'((root_t - ROOT_W'(255)) >> 1);
    end else if (exact) begin
      rad_d = -(m >> 1);
    end else begin
      rad_d = -((m - COORD_W'(1)) >> 1);
    end
  end

  // Output register
  logic [COORD_W-1:0] rad_q, ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_s[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= rad_d;
      ang_q <= ang_d;
    end
  end

  assign polar_o.valid       = out_valid_q;
  assign polar_o.radius_code = rad_q;
  assign polar_o.angle_code  = ang_q;

endmodule

>>> verif/c2p_polar_checker.sv
// Checker for the cartesian-to-polar converter: predicts each polar result and compares it.
`timescale 1ns / 1ps

module c2p_polar_checker
  import c2p_pkg::*;
#(
  parameter int CORDIC_STAGES = 16,
  parameter int GUARD_BITS    = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  c2p_point_if  point_mon,
  c2p_polar_if  polar_mon,
  output int    err_cnt_o,
  output int    pending_o
);

  // atan(2^-i) in units of 2^-24 angle steps (one step = pi/128 rad)
  localparam logic [31:0] ARCTAN_STEPS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] radius;
    logic signed [COORD_W-1:0] angle;
  } polar_exp_t;

  polar_exp_t polar_exp_q [$];
  polar_exp_t want;
  int         err_cnt = 0;

  // sqrt(x*x+y*y) - 127.5 truncated toward zero, from the floor root of 4*(x*x+y*y)
  function automatic logic signed [COORD_W-1:0] radius_code_of(int xv, int yv);
    int unsigned quad;
    int unsigned rt;
    int unsigned m;
    int          r;
    quad = 4 * (xv * xv + yv * yv);
    rt   = 0;
    while ((rt + 1) * (rt + 1) <= quad) rt++;
    if (rt >= 255) begin
      r = int'((rt - 255) >> 1);
    end else begin
      m = 255 - rt;
      r = (rt * rt == quad) ? -int'(m >> 1) : -int'((m - 1) >> 1);
    end
    return r[COORD_W-1:0];
  endfunction

  // Vectoring CORDIC on |x|, |y|, then rounding to a code and quadrant fix-up
  function automatic logic signed [COORD_W-1:0] angle_code_of(int xv, int yv);
    longint ax, ay, vx, vy, ox, z, full, half, stp, a;
    int     g, n, sh, i;
    g    = (GUARD_BITS < 1) ? 1 : (GUARD_BITS > 24) ? 24 : GUARD_BITS;
    n    = (CORDIC_STAGES < 0) ? 0 : (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    sh   = 24 - g;
    full = longint'(64) <<< g;
    half = longint'(1) <<< (g - 1);
    ax   = (xv < 0) ? -xv : xv;
    ay   = (yv < 0) ? -yv : yv;
    z    = 0;
    if (ay == 0) begin
      z = 0;
    end else if (ax == 0) begin
      // right angle, exact
      z = full;
    end else begin
      vx = ax <<< g;
      vy = ay <<< g;
      for (i = 0; i < n; i++) begin
        stp = longint'(ARCTAN_STEPS[i]);
        if (sh > 0) stp = (stp + (longint'(1) <<< (sh - 1))) >>> sh;
        ox = vx;
        if (vy >= 0) begin
          vx = vx + (vy >>> i);
          vy = vy - (ox >>> i);
          z  = z + stp;
        end else begin
          vx = vx - (vy >>> i);
          vy = vy + (ox >>> i);
          z  = z - stp;
        end
      end
      if (z < 0) z = 0;
      if (z > full) z = full;
    end
    // sign of the angle flips when exactly one coordinate is negative
    if ((xv < 0) != (yv < 0)) begin
      a = -((z + half) >>> g);
    end else if (z < half) begin
      a = 0;
    end else begin
      a = (z - half) >>> g;
    end
    if (xv < 0) begin
      a = a + ((yv < 0) ? -127 : 128);
    end else if (yv > 0) begin
      a = a + 1;
    end
    return a[COORD_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Queue a prediction on every point transfer, compare on every result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polar_exp_q.delete();
      pending_o <= 0;
      err_cnt_o <= err_cnt;
    end else begin
      if (point_mon.valid && point_mon.ready) begin
        want.x      = point_mon.x_coord;
        want.y      = point_mon.y_coord;
        want.radius = radius_code_of(int'(point_mon.x_coord), int'(point_mon.y_coord));
        want.angle  = angle_code_of(int'(point_mon.x_coord), int'(point_mon.y_coord));
        polar_exp_q.push_back(want);
      end
      if (polar_mon.valid && polar_mon.ready) begin
        if (polar_exp_q.size() == 0) begin
          report_mismatch($sformatf("result radius=%0d angle=%0d with no point pending",
                                    polar_mon.radius_code, polar_mon.angle_code));
        end else begin
          want = polar_exp_q.pop_front();
          if (polar_mon.radius_code !== want.radius)
            report_mismatch($sformatf("point (%0d,%0d) radius_code %0d, expected %0d",
                                      want.x, want.y, polar_mon.radius_code, want.radius));
          if (polar_mon.angle_code !== want.angle)
            report_mismatch($sformatf("point (%0d,%0d) angle_code %0d, expected %0d",
                                      want.x, want.y, polar_mon.angle_code, want.angle));
        end
      end
      pending_o <= polar_exp_q.size();
      err_cnt_o <= err_cnt;
    end
  end

endmodule

>>> verif/tb_cartesian_to_polar_8bit.sv
// Testbench top for the cartesian-to-polar converter: clock, reset, point stimulus and verdict.
`timescale 1ns / 1ps

module tb_cartesian_to_polar_8bit
  import c2p_pkg::*;
;

  localparam int STAGES = 16;
  localparam int GUARD  = 16;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   err_cnt;
  int   pending;
  bit   gap_on   = 1'b1;
  bit   stall_on = 1'b1;

  c2p_point_if point_bus ();
  c2p_polar_if polar_bus ();

  cartesian_to_polar_8bit #(
    .CORDIC_STAGES(STAGES),
    .GUARD_BITS   (GUARD)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .point_i(point_bus),
    .polar_o(polar_bus)
  );

  c2p_polar_checker #(
    .CORDIC_STAGES(STAGES),
    .GUARD_BITS   (GUARD)
  ) chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_mon(point_bus),
    .polar_mon(polar_bus),
    .err_cnt_o(err_cnt),
    .pending_o(pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one point, optionally after an idle burst, and hold it until the transfer
  task automatic send_point(input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py);
    if (gap_on && $urandom_range(0, 3) == 0) begin
      point_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    point_bus.valid   <= 1'b1;
    point_bus.x_coord <= px;
    point_bus.y_coord <= py;
    @(posedge clk_i);
    while (!point_bus.ready) @(posedge clk_i);
  endtask

  // Stop offering points until every predicted result has come back
  task automatic wait_drained();
    point_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random points: mostly in range, plus raw bytes, axes, tiny vectors and diagonals
  task automatic run_random(input int count);
    int k;
    logic signed [COORD_W-1:0] px, py;
    for (k = 0; k < count; k++) begin
      px = 8'(int'($urandom_range(0, 253)) - 127);
      py = 8'(int'($urandom_range(0, 253)) - 127);
      case ($urandom_range(0, 9))
        0: begin
          px = 8'($urandom);
          py = 8'($urandom);
        end
        1: begin
          if ($urandom_range(0, 1)) px = '0;
          else py = '0;
        end
        2: begin
          px = 8'(int'($urandom_range(0, 8)) - 4);
          py = 8'(int'($urandom_range(0, 8)) - 4);
        end
        3: begin
          px = 8'($urandom_range(0, 126));
          py = $urandom_range(0, 1) ? px : -px;
          if ($urandom_range(0, 1)) px = -px;
        end
        default: ;
      endcase
      send_point(px, py);
    end
  endtask

  // Result side: ready drops in random bursts while stalls are enabled
  initial begin : result_sink
    polar_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 7) == 0) begin
        polar_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      polar_bus.ready <= 1'b1;
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    rst_ni            <= 1'b0;
    point_bus.valid   <= 1'b0;
    point_bus.x_coord <= '0;
    point_bus.y_coord <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners, axes, origin, diagonals and the out-of-range byte values
    send_point(-127, -127);
    send_point(126, 126);
    send_point(-127, 126);
    send_point(126, -127);
    send_point(0, 0);
    send_point(0, 1);
    send_point(0, -1);
    send_point(1, 0);
    send_point(-1, 0);
    send_point(0, 126);
    send_point(0, -127);
    send_point(126, 0);
    send_point(-127, 0);
    send_point(1, 1);
    send_point(-1, -1);
    send_point(1, -1);
    send_point(-1, 1);
    send_point(-128, -128);
    send_point(127, 127);
    send_point(-128, 0);
    send_point(0, -128);
    send_point(90, -90);
    send_point(-3, 100);
    send_point(100, -3);
    wait_drained();

    run_random(400);

    // back-to-back stretch with no idling on either side
    gap_on   = 1'b0;
    stall_on = 1'b0;
    run_random(300);
    wait_drained();

    gap_on   = 1'b1;
    stall_on = 1'b1;
    run_random(226);

    // closing stretch at full rate
    gap_on   = 1'b0;
    stall_on = 1'b0;
    run_random(100);

    wait_drained();
    repeat (STAGES + 4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
